/* hw/rtl/ups_pkg.sv */
// Shared types and constants for the URL path sanitizer.
// Used by the front, the command queue, the back and the top level.
`timescale 1ns / 1ps

package ups_pkg;

  // Command from the front to the back part
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,  // emit one path byte
    CMD_FINAL = 2'd1,  // emit the final word with the verdict
    CMD_INDEX = 2'd2   // emit "index.html", then an accepting final word
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       bad;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned INDEX_LEN   = 10;
  localparam int unsigned ROOT_W      = 6;
  localparam logic [ROOT_W-1:0] ROOT_RESET = 6'd4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

endpackage

/* hw/rtl/ups_front.sv */
// Front part: accepts path words, tracks segment state and capacity,
// and pushes commands into the queue. Depends on ups_pkg.
`timescale 1ns / 1ps

module ups_front #(
  parameter int unsigned PATH_CAPACITY = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ups_pkg::ROOT_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_end_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output ups_pkg::cmd_t              push_cmd_o
);

  localparam int unsigned CNT_W = $clog2(PATH_CAPACITY);
  localparam int unsigned SUM_W = $clog2(PATH_CAPACITY + 80);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(PATH_CAPACITY - 1);

  localparam logic [1:0] PH_START    = 2'd0;
  localparam logic [1:0] PH_SEGMENT  = 2'd1;
  localparam logic [1:0] PH_IGNORE   = 2'd2;
  localparam logic [1:0] PH_REJECTED = 2'd3;

  logic [1:0]                 phase_q, phase_d;
  logic [1:0]                 seg_len_q, seg_len_d;
  logic                       first_dot_q, first_dot_d;
  logic                       second_dot_q, second_dot_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       on_slash_q, on_slash_d;
  logic [ups_pkg::ROOT_W-1:0] root_q;

  logic [SUM_W-1:0] used;
  logic             fits_one, fits_index, dot_seg, allowed, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign used       = SUM_W'(root_q) + SUM_W'(count_q);
  assign fits_one   = (used + SUM_W'(1)) <= LIMIT;
  assign fits_index = (used + SUM_W'(ups_pkg::INDEX_LEN)) <= LIMIT;
  assign dot_seg    = (seg_len_q == 2'd1 && first_dot_q) ||
                      (seg_len_q == 2'd2 && first_dot_q && second_dot_q);

  always_comb begin
    allowed = (in_byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
              in_byte_i == ups_pkg::CH_DOT || in_byte_i == ups_pkg::CH_UNDER ||
              in_byte_i == ups_pkg::CH_DASH || in_byte_i == ups_pkg::CH_TILDE;
  end

  always_comb begin
    phase_d      = phase_q;
    seg_len_d    = seg_len_q;
    first_dot_d  = first_dot_q;
    second_dot_d = second_dot_q;
    count_d      = count_q;
    on_slash_d   = on_slash_q;
    push_o       = 1'b0;
    push_cmd_o   = '{kind: ups_pkg::CMD_BYTE, data: in_byte_i, bad: 1'b0};
    if (accept) begin
      if (in_end_i) begin
        push_o          = 1'b1;
        push_cmd_o.kind = ups_pkg::CMD_FINAL;
        push_cmd_o.data = 8'd0;
        if (phase_q == PH_START || phase_q == PH_REJECTED) begin
          push_cmd_o.bad = 1'b1;
        end else if (phase_q == PH_SEGMENT && dot_seg) begin
          push_cmd_o.bad = 1'b1;
        end else if (on_slash_q) begin
          if (fits_index) begin
            push_cmd_o.kind = ups_pkg::CMD_INDEX;
          end else begin
            push_cmd_o.bad = 1'b1;
          end
        end
        // start over for the next path
        phase_d      = PH_START;
        seg_len_d    = 2'd0;
        first_dot_d  = 1'b0;
        second_dot_d = 1'b0;
        count_d      = '0;
        on_slash_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_START: begin
            if (in_byte_i != ups_pkg::CH_SLASH || !fits_one) begin
              phase_d = PH_REJECTED;
            end else begin
              push_o       = 1'b1;
              count_d      = count_q + CNT_W'(1);
              phase_d      = PH_SEGMENT;
              seg_len_d    = 2'd0;
              first_dot_d  = 1'b0;
              second_dot_d = 1'b0;
              on_slash_d   = 1'b1;
            end
          end
          PH_SEGMENT: begin
            if (in_byte_i == ups_pkg::CH_SLASH) begin
              if (seg_len_q == 2'd0) begin
                phase_d = PH_IGNORE;
              end else if (dot_seg || !fits_one) begin
                phase_d = PH_REJECTED;
              end else begin
                push_o       = 1'b1;
                count_d      = count_q + CNT_W'(1);
                seg_len_d    = 2'd0;
                first_dot_d  = 1'b0;
                second_dot_d = 1'b0;
                on_slash_d   = 1'b1;
              end
            end else if (!allowed || !fits_one) begin
              phase_d = PH_REJECTED;
            end else begin
              push_o  = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (seg_len_q == 2'd0) begin
                first_dot_d = (in_byte_i == ups_pkg::CH_DOT);
              end else if (seg_len_q == 2'd1) begin
                second_dot_d = (in_byte_i == ups_pkg::CH_DOT);
              end
              if (seg_len_q != 2'd3) begin
                seg_len_d = seg_len_q + 2'd1;
              end
              on_slash_d = 1'b0;
            end
          end
          default: begin
            // ignore or rejected: drop the word
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      seg_len_q    <= 2'd0;
      first_dot_q  <= 1'b0;
      second_dot_q <= 1'b0;
      count_q      <= '0;
      on_slash_q   <= 1'b0;
      root_q       <= ups_pkg::ROOT_RESET;
    end else begin
      phase_q      <= phase_d;
      seg_len_q    <= seg_len_d;
      first_dot_q  <= first_dot_d;
      second_dot_q <= second_dot_d;
      count_q      <= count_d;
      on_slash_q   <= on_slash_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* hw/rtl/ups_queue.sv */
// Short command queue between the front and the back part.
// Depends on ups_pkg for the command type and depth.
`timescale 1ns / 1ps

module ups_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ups_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ups_pkg::cmd_t head_o
);

  localparam int unsigned CW = ups_pkg::QPTR_W + 1;
  localparam int unsigned PW = ups_pkg::QPTR_W;

  ups_pkg::cmd_t              mem_q [ups_pkg::QUEUE_DEPTH];
  logic [ups_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]              count_q;

  assign full_o  = count_q == CW'(ups_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* hw/rtl/ups_back.sv */
// Back part: turns queued commands into result words through an output
// register, expanding the index.html run. Depends on ups_pkg.
`timescale 1ns / 1ps

module ups_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ups_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_present_o,
  output logic          out_final_o,
  output logic          out_verdict_o
);

  localparam int unsigned IDX_W = $clog2(ups_pkg::INDEX_LEN + 1);

  function automatic logic [7:0] index_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      IDX_W'(0): c = 8'h69;  // i
      IDX_W'(1): c = 8'h6E;  // n
      IDX_W'(2): c = 8'h64;  // d
      IDX_W'(3): c = 8'h65;  // e
      IDX_W'(4): c = 8'h78;  // x
      IDX_W'(5): c = 8'h2E;  // .
      IDX_W'(6): c = 8'h68;  // h
      IDX_W'(7): c = 8'h74;  // t
      IDX_W'(8): c = 8'h6D;  // m
      IDX_W'(9): c = 8'h6C;  // l
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             present_q, present_d;
  logic             final_q, final_d;
  logic             verdict_q, verdict_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d   = valid_q;
    byte_d    = byte_q;
    present_d = present_q;
    final_d   = final_q;
    verdict_d = verdict_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    if (load) begin
      valid_d   = cmd_valid_i;
      byte_d    = 8'd0;
      present_d = 1'b0;
      final_d   = 1'b0;
      verdict_d = 1'b0;
      if (cmd_valid_i) begin
        case (cmd_i.kind)
          ups_pkg::CMD_BYTE: begin
            byte_d    = cmd_i.data;
            present_d = 1'b1;
            pop_o     = 1'b1;
          end
          ups_pkg::CMD_INDEX: begin
            // walk the name, then close with an accepting final word
            if (idx_q == IDX_W'(ups_pkg::INDEX_LEN)) begin
              final_d = 1'b1;
              idx_d   = '0;
              pop_o   = 1'b1;
            end else begin
              byte_d    = index_char(idx_q);
              present_d = 1'b1;
              idx_d     = idx_q + IDX_W'(1);
            end
          end
          default: begin
            final_d   = 1'b1;
            verdict_d = cmd_i.bad;
            pop_o     = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    present_q <= present_d;
    final_q   <= final_d;
    verdict_q <= verdict_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign out_present_o = present_q;
  assign out_final_o   = final_q;
  assign out_verdict_o = verdict_q;

endmodule

/* hw/rtl/url_path_sanitizer_core.sv */
// Top level of the URL path sanitizer: front, command queue and back part.
// Depends on ups_pkg, ups_front, ups_queue and ups_back.
//
//  channel  | direction | tdata           | tlast     | tuser
//  s_axis   | in        | [7:0] path_byte | is_end    | -
//  m_axis   | out       | [7:0] out_byte  | final_res | [0] byte_present, [1] verdict
//  cfg      | in        | cfg_wdata_i = root_length, written when cfg_we_i is high
//
// The front takes one word per cycle while the queue is not full and
// classifies it in that cycle. Byte words pass through the command queue and
// the output register; an end word after a trailing slash expands into 11
// result words, one per cycle unless m_axis stalls, from the back part. A
// 4-entry command queue and the output register let the input keep flowing
// while results stall, until the queue fills. Reset clears all control state and sets root_length to 4.
`timescale 1ns / 1ps

module url_path_sanitizer_core #(
  parameter int unsigned PATH_CAPACITY = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ups_pkg::ROOT_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] path_byte
  input  logic                       s_axis_tlast,   // is_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // final_res
  output logic [1:0]                 m_axis_tuser    // [0] byte_present, [1] verdict
);

  logic          push, full, pop, head_valid;
  ups_pkg::cmd_t push_cmd, head;
  logic          present, verdict;

  ups_front #(
    .PATH_CAPACITY(PATH_CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ups_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .head_o    (head)
  );

  ups_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (head_valid),
    .cmd_i        (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_present_o(present),
    .out_final_o  (m_axis_tlast),
    .out_verdict_o(verdict)
  );

  assign m_axis_tuser = {verdict, present};

endmodule
